// File: hdl/lsb_pkg.sv
package lsb_pkg;

  localparam logic [2:0] CMD_SCHEDULE = 3'd0;
  localparam logic [2:0] CMD_SET_TICKETS = 3'd1;
  localparam logic [2:0] CMD_SET_STATUS = 3'd2;
  localparam logic [2:0] CMD_WAKE = 3'd3;

  localparam logic [1:0] ST_SLEEPING = 2'd1;
  localparam logic [1:0] ST_RUNNABLE = 2'd2;
  localparam logic [1:0] ST_RUNNING = 2'd3;

  localparam logic [1:0] RES_DONE = 2'd0;
  localparam logic [1:0] RES_NONE = 2'd1;
  localparam logic [1:0] RES_REJECT = 2'd2;

  localparam logic [30:0] LCG_MUL = 31'd1103515245;
  localparam logic [30:0] LCG_INC = 31'd12345;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  entry;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [5:0]  winner;
    logic [15:0] entry_tickets;
    logic [15:0] entry_boosts;
    logic [31:0] entry_runs;
    logic [1:0]  entry_status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] tickets;
    logic [15:0] boosts;
    logic [31:0] runs;
  } entry_t;

endpackage

// File: hdl/lsb_mem.sv
module lsb_mem #(
  parameter int Depth = 64,
  localparam int AW = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output lsb_pkg::entry_t rdata_o,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  lsb_pkg::entry_t wdata_i
);

  lsb_pkg::entry_t mem [Depth];
  lsb_pkg::entry_t data_q;
  logic [Depth-1:0] vld_q;
  logic rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      data_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  // entries never written read as reset value
  assign rdata_o = rd_vld_q ? data_q : '0;

endmodule

// File: hdl/lsb_mod.sv
module lsb_mod #(
  parameter int DvdW = 31,
  parameter int DivW = 23
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] rem_o
);

  localparam int CW = $clog2(DvdW + 1);

  logic            busy_q, done_q;
  logic [CW-1:0]   cnt_q;
  logic [DvdW-1:0] dvd_q;
  logic [DivW-1:0] div_q, rem_q;
  logic [DivW:0]   trial, diff;
  logic            ge;

  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign ge = trial >= {1'b0, div_q};
  assign diff = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= CW'(DvdW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o = rem_q;

endmodule

// File: hdl/lottery_scheduler_with_boost_core.sv
// Lottery arbiter over a table held in one single-port-read memory. A schedule
// command scans the table twice at one entry per cycle through the memory read
// port, plus LCG update and a 31-step modulo unit; the second scan stops when
// the winner is found. One item is in work at a time; the next is taken while
// the previous result waits in the output register.
module lottery_scheduler_with_boost_core #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lsb_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lsb_pkg::out_item_t  out_data_o
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int TW = 17 + AW;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_LCG_MUL, S_LCG_ADD, S_DIV, S_PICK, S_ENT_RD, S_ENT_WAIT, S_DONE
  } state_e;

  state_e state_q;
  logic [AW:0]     scan_cnt_q;
  logic            rd_pend_q, found_q, wr_q, out_valid_q;
  logic [AW-1:0]   rd_idx_q, idx_q;
  logic [TW-1:0]   total_q, run_q, draw_q, run_n, eff;
  logic [30:0]     seed_q, prod_q, seed_n, prod_full;
  logic [2:0]      cmd_q;
  logic [15:0]     val_q;
  logic [5:0]      winner_q;
  logic [1:0]      code_q;
  lsb_pkg::entry_t ent_q, rdata, upd;
  lsb_pkg::out_item_t out_q;
  logic            scan_issue, mem_re, mem_we, out_free, scan_end, oob;
  logic [AW-1:0]   raddr;
  logic            div_done;
  logic [TW-1:0]   div_rem;
  logic [16:0]     bsum;

  assign out_free = !out_valid_q || out_ready_i;
  assign scan_issue = (state_q == S_SUM || (state_q == S_PICK && !found_q))
                      && scan_cnt_q < (AW+1)'(TABLE_ENTRIES);
  assign mem_re = scan_issue || state_q == S_ENT_RD;
  assign raddr = (state_q == S_ENT_RD) ? idx_q : scan_cnt_q[AW-1:0];
  assign mem_we = state_q == S_DONE && out_free && wr_q;
  assign scan_end = scan_cnt_q == (AW+1)'(TABLE_ENTRIES) && !rd_pend_q;
  assign eff = (rdata.boosts != '0) ? TW'({rdata.tickets, 1'b0})
                                    : TW'(rdata.tickets);
  assign run_n = run_q + eff;
  assign prod_full = seed_q * lsb_pkg::LCG_MUL;
  assign seed_n = prod_q + lsb_pkg::LCG_INC;
  assign oob = {26'd0, in_data_i.entry} >= 32'(TABLE_ENTRIES);
  assign bsum = {1'b0, rdata.boosts} + {1'b0, val_q};

  lsb_mem #(.Depth(TABLE_ENTRIES)) u_mem (
    .clk_i, .rst_ni,
    .re_i(mem_re), .raddr_i(raddr), .rdata_o(rdata),
    .we_i(mem_we), .waddr_i(idx_q), .wdata_i(ent_q)
  );

  lsb_mod #(.DvdW(31), .DivW(TW)) u_mod (
    .clk_i, .rst_ni,
    .start_i(state_q == S_LCG_ADD), .dividend_i(seed_n), .divisor_i(total_q),
    .done_o(div_done), .rem_o(div_rem)
  );

  always_comb begin
    upd = rdata;
    case (cmd_q)
      lsb_pkg::CMD_SET_TICKETS: begin
        if (val_q != '0) upd.tickets = val_q;
      end
      lsb_pkg::CMD_SET_STATUS: begin
        upd.status = val_q[1:0];
      end
      lsb_pkg::CMD_WAKE: begin
        if (rdata.status == lsb_pkg::ST_SLEEPING) begin
          upd.boosts = bsum[16] ? 16'hFFFF : bsum[15:0];
          upd.status = lsb_pkg::ST_RUNNABLE;
        end
      end
      default: upd = rdata;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_cnt_q <= '0;
      rd_pend_q <= 1'b0;
      found_q <= 1'b0;
      wr_q <= 1'b0;
      out_valid_q <= 1'b0;
      seed_q <= '0;
    end else begin
      rd_pend_q <= scan_issue;
      if (scan_issue) scan_cnt_q <= scan_cnt_q + (AW+1)'(1);
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_data_i.command == lsb_pkg::CMD_SCHEDULE) begin
              scan_cnt_q <= '0;
              total_q <= '0;
              state_q <= S_SUM;
            end else if (oob) begin
              code_q <= lsb_pkg::RES_NONE;
              ent_q <= '0;
              wr_q <= 1'b0;
              state_q <= S_DONE;
            end else begin
              state_q <= S_ENT_RD;
            end
          end
        end
        S_SUM: begin
          if (rd_pend_q && rdata.status == lsb_pkg::ST_RUNNABLE) total_q <= total_q + eff;
          if (scan_end) begin
            if (total_q == '0) begin
              code_q <= lsb_pkg::RES_NONE;
              winner_q <= '0;
              ent_q <= '0;
              wr_q <= 1'b0;
              state_q <= S_DONE;
            end else begin
              state_q <= S_LCG_MUL;
            end
          end
        end
        S_LCG_MUL: begin
          prod_q <= prod_full;
          state_q <= S_LCG_ADD;
        end
        S_LCG_ADD: begin
          seed_q <= seed_n;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            draw_q <= div_rem;
            scan_cnt_q <= '0;
            run_q <= '0;
            found_q <= 1'b0;
            state_q <= S_PICK;
          end
        end
        S_PICK: begin
          if (rd_pend_q && !found_q && rdata.status == lsb_pkg::ST_RUNNABLE) begin
            run_q <= run_n;
            if (run_n > draw_q) begin
              found_q <= 1'b1;
              idx_q <= rd_idx_q;
              winner_q <= 6'(rd_idx_q);
              ent_q.status <= lsb_pkg::ST_RUNNING;
              ent_q.tickets <= rdata.tickets;
              ent_q.boosts <= (rdata.boosts != '0) ? rdata.boosts - 16'd1 : rdata.boosts;
              ent_q.runs <= rdata.runs + 32'd1;
            end
          end
          if ((found_q || scan_cnt_q == (AW+1)'(TABLE_ENTRIES)) && !rd_pend_q) begin
            code_q <= lsb_pkg::RES_DONE;
            wr_q <= 1'b1;
            state_q <= S_DONE;
          end
        end
        S_ENT_RD: begin
          state_q <= S_ENT_WAIT;
        end
        S_ENT_WAIT: begin
          ent_q <= upd;
          code_q <= (cmd_q == lsb_pkg::CMD_SET_TICKETS && val_q == '0) ?
                    lsb_pkg::RES_REJECT : lsb_pkg::RES_DONE;
          wr_q <= 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q <= '{result_code: code_q, winner: winner_q,
                       entry_tickets: ent_q.tickets, entry_boosts: ent_q.boosts,
                       entry_runs: ent_q.runs, entry_status: ent_q.status};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_IDLE && in_valid_i) begin
        cmd_q <= in_data_i.command;
        val_q <= in_data_i.value;
        idx_q <= AW'(in_data_i.entry);
        winner_q <= in_data_i.entry;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_issue) rd_idx_q <= scan_cnt_q[AW-1:0];
  end

  assign in_ready_o = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted but block still idle");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("modulo result outside wait state");

  a_draw_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PICK |-> draw_q < total_q)
    else $error("draw not below total");

  a_write_frees_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> out_valid_o && in_ready_o)
    else $error("writeback without result");

endmodule

// File: tb/sv/tb_lottery_scheduler_with_boost_core.sv
module tb_lottery_scheduler_with_boost_core;

  localparam int NENT = 64;
  localparam int CYCLE_LIMIT = 900000;
  localparam logic [2:0] CMD_QUERY = 3'd4;
  localparam logic [1:0] ST_UNUSED = 2'd0;

  class lottery_scoreboard;
    logic [1:0] status_q[NENT];
    logic [15:0] tickets_q[NENT];
    logic [15:0] boosts_q[NENT];
    logic [31:0] runs_q[NENT];
    logic [30:0] seed;
    lsb_pkg::out_item_t pending_results[$];
    int errors;

    function void clear();
      for (int i = 0; i < NENT; i++) begin
        status_q[i] = ST_UNUSED;
        tickets_q[i] = '0;
        boosts_q[i] = '0;
        runs_q[i] = '0;
      end
      seed = '0;
      errors = 0;
      pending_results.delete();
    endfunction

    function logic [16:0] weight(int i);
      return boosts_q[i] != 0 ? {tickets_q[i], 1'b0} : {1'b0, tickets_q[i]};
    endfunction

    function lsb_pkg::out_item_t entry_report(logic [1:0] code, int i);
      lsb_pkg::out_item_t r;
      r.result_code = code;
      r.winner = i[5:0];
      r.entry_tickets = tickets_q[i];
      r.entry_boosts = boosts_q[i];
      r.entry_runs = runs_q[i];
      r.entry_status = status_q[i];
      return r;
    endfunction

    function void note_input(lsb_pkg::in_item_t it);
      logic [31:0] total;
      logic [31:0] draw;
      logic [31:0] run;
      logic [16:0] b;
      int w;
      int i;
      lsb_pkg::out_item_t r;
      i = it.entry;
      if (it.command == lsb_pkg::CMD_SCHEDULE) begin
        total = 0;
        for (int k = 0; k < NENT; k++)
          if (status_q[k] == lsb_pkg::ST_RUNNABLE) total += weight(k);
        if (total == 0) begin
          r = '0;
          r.result_code = lsb_pkg::RES_NONE;
          pending_results.push_back(r);
          return;
        end
        seed = seed * lsb_pkg::LCG_MUL + lsb_pkg::LCG_INC;
        draw = {1'b0, seed} % total;
        run = 0;
        w = NENT - 1;
        for (int k = 0; k < NENT; k++) begin
          if (status_q[k] == lsb_pkg::ST_RUNNABLE) begin
            run += weight(k);
            if (run > draw) begin
              w = k;
              break;
            end
          end
        end
        status_q[w] = lsb_pkg::ST_RUNNING;
        runs_q[w] = runs_q[w] + 1;
        if (boosts_q[w] != 0) boosts_q[w] = boosts_q[w] - 1;
        pending_results.push_back(entry_report(lsb_pkg::RES_DONE, w));
        return;
      end
      if (it.command == lsb_pkg::CMD_SET_TICKETS) begin
        if (it.value == 0) begin
          pending_results.push_back(entry_report(lsb_pkg::RES_REJECT, i));
          return;
        end
        tickets_q[i] = it.value;
      end else if (it.command == lsb_pkg::CMD_SET_STATUS) begin
        status_q[i] = it.value[1:0];
      end else if (it.command == lsb_pkg::CMD_WAKE) begin
        if (status_q[i] == lsb_pkg::ST_SLEEPING) begin
          b = {1'b0, boosts_q[i]} + {1'b0, it.value};
          boosts_q[i] = b[16] ? 16'hffff : b[15:0];
          status_q[i] = lsb_pkg::ST_RUNNABLE;
        end
      end
      pending_results.push_back(entry_report(lsb_pkg::RES_DONE, i));
    endfunction

    function void check_result(lsb_pkg::out_item_t got);
      lsb_pkg::out_item_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.result_code !== exp_r.result_code)
        report_field("result_code", exp_r.result_code, got.result_code);
      if (got.winner !== exp_r.winner)
        report_field("winner", exp_r.winner, got.winner);
      if (got.entry_tickets !== exp_r.entry_tickets)
        report_field("entry_tickets", exp_r.entry_tickets, got.entry_tickets);
      if (got.entry_boosts !== exp_r.entry_boosts)
        report_field("entry_boosts", exp_r.entry_boosts, got.entry_boosts);
      if (got.entry_runs !== exp_r.entry_runs)
        report_field("entry_runs", exp_r.entry_runs, got.entry_runs);
      if (got.entry_status !== exp_r.entry_status)
        report_field("entry_status", exp_r.entry_status, got.entry_status);
    endfunction

    function void report_field(string name, logic [31:0] e, logic [31:0] a);
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lsb_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lsb_pkg::out_item_t out_data;
  lottery_scoreboard sb;
  int cycles = 0;
  int hold_off = 0;
  bit big_stall = 1'b0;

  always #5 clk = ~clk;

  lottery_scheduler_with_boost_core #(.TABLE_ENTRIES(NENT)) i_dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (big_stall) begin
      big_stall <= 1'b0;
      hold_off <= 2000;
      out_ready <= 1'b0;
    end else begin
      case (cycles[9:8])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(3) != 0);
        default: out_ready <= ($urandom_range(1) != 0);
      endcase
    end
  end

  task automatic send_item(logic [2:0] cmd, logic [5:0] ent, logic [15:0] val);
    lsb_pkg::in_item_t it;
    it.command = cmd;
    it.entry = ent;
    it.value = val;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_item();
    logic [2:0] cmd;
    logic [5:0] ent;
    logic [15:0] val;
    int p;
    p = $urandom_range(99);
    ent = $urandom_range(7) == 0 ? 6'($urandom) : 6'($urandom_range(11));
    case ($urandom_range(3))
      0: val = 16'($urandom);
      1: val = 16'($urandom_range(4));
      2: val = 16'hffff - 16'($urandom_range(3));
      default: val = 16'($urandom_range(300));
    endcase
    if (p < 35) cmd = lsb_pkg::CMD_SCHEDULE;
    else if (p < 50) cmd = lsb_pkg::CMD_SET_TICKETS;
    else if (p < 70) begin
      cmd = lsb_pkg::CMD_SET_STATUS;
      if ($urandom_range(3) != 0)
        val = {14'($urandom),
               ($urandom_range(1) != 0) ? lsb_pkg::ST_SLEEPING : lsb_pkg::ST_RUNNABLE};
    end else if (p < 85) cmd = lsb_pkg::CMD_WAKE;
    else if (p < 95) cmd = CMD_QUERY;
    else cmd = 3'($urandom_range(7, 5));
    send_item(cmd, ent, val);
  endtask

  initial begin
    int burst;
    sb = new();
    sb.clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(lsb_pkg::CMD_SCHEDULE, 6'd0, 16'd0);
    send_item(lsb_pkg::CMD_SET_TICKETS, 6'd3, 16'd0);
    send_item(lsb_pkg::CMD_SET_TICKETS, 6'd3, 16'hffff);
    send_item(lsb_pkg::CMD_SET_TICKETS, 6'd63, 16'd1);
    send_item(lsb_pkg::CMD_SET_STATUS, 6'd3, 16'hfffe);
    send_item(lsb_pkg::CMD_SET_STATUS, 6'd63, {14'd0, lsb_pkg::ST_SLEEPING});
    send_item(lsb_pkg::CMD_WAKE, 6'd63, 16'hffff);
    send_item(lsb_pkg::CMD_WAKE, 6'd63, 16'd5);
    send_item(lsb_pkg::CMD_SET_STATUS, 6'd63, {14'd0, lsb_pkg::ST_SLEEPING});
    send_item(lsb_pkg::CMD_WAKE, 6'd63, 16'd10);
    send_item(lsb_pkg::CMD_SCHEDULE, 6'd0, 16'd0);
    send_item(lsb_pkg::CMD_SCHEDULE, 6'd0, 16'd0);
    send_item(lsb_pkg::CMD_SET_STATUS, 6'd0, {14'd0, lsb_pkg::ST_RUNNABLE});
    send_item(lsb_pkg::CMD_SCHEDULE, 6'd0, 16'd0);
    send_item(CMD_QUERY, 6'd63, 16'd0);
    send_item(3'd5, 6'd3, 16'd0);
    send_item(3'd7, 6'd0, 16'd0);
    send_item(lsb_pkg::CMD_SET_STATUS, 6'd3, {14'd0, ST_UNUSED});
    send_item(lsb_pkg::CMD_WAKE, 6'd3, 16'd1);
    drain();

    for (int n = 0; n < 1430;) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) random_item();
      n += burst;
      if (n > 300 && n < 330) begin
        big_stall <= 1'b1;
        for (int k = 0; k < 6; k++) random_item();
        n += 6;
      end
      if (n > 700 && n < 730) drain();
      if ($urandom_range(2) != 0) idle_cycles($urandom_range(1, 200));
    end
    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
